>>> hw/rtl/zvfa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package zvfa_pkg;

    // default sizes
    localparam int ZONES_DEF     = 1024;
    localparam int MATERIALS_DEF = 64;

    // field widths
    localparam int ACC_W           = 40;
    localparam int VOL_W           = 24;
    localparam int ZONE_IDX_W      = 10;
    localparam int MAT_IDX_W       = 6;
    localparam int MASK_W          = 64;
    localparam int FRAC_W          = 17;
    localparam int ZONE_ADDR_MAX_W = 16;

    // one quotient bit per divider step
    localparam int QUO_STEPS = 17;

    localparam logic [FRAC_W-1:0] FRAC_ONE = FRAC_W'(65536);

    typedef enum logic [1:0] {
        OP_ACCUMULATE = 2'd0,
        OP_QUERY      = 2'd1,
        OP_CLEAR      = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_RUN,
        DIV_DONE
    } div_state_t;

    typedef struct packed {
        logic [ACC_W-1:0] total;
        logic [ACC_W-1:0] selected;
    } acc_pair_t;

    typedef struct packed {
        logic                       valid;
        op_t                        op;
        logic                       in_range;
        logic                       selected;
        logic [ZONE_ADDR_MAX_W-1:0] zone;
        logic [VOL_W-1:0]           volume;
    } store_req_t;

    typedef struct packed {
        logic init_done;
        logic query_pending;
    } store_status_t;

    typedef struct packed {
        logic      valid;
        logic      empty;
        acc_pair_t acc;
    } query_rsp_t;

    typedef struct packed {
        logic              valid;
        logic              empty;
        logic [FRAC_W-1:0] frac;
    } div_result_t;

    // saturating accumulate
    function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] acc,
                                                 input logic [VOL_W-1:0] vol);
        logic [ACC_W:0] sum;
        sum = {1'b0, acc} + {{(ACC_W + 1 - VOL_W){1'b0}}, vol};
        return sum[ACC_W] ? {ACC_W{1'b1}} : sum[ACC_W-1:0];
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/zone_volume_fraction_accumulator.sv
// accumulate and clear: one transfer per cycle, memory written in the cycle after the transfer
// query: s1 stage, then the 17-step divider (one quotient bit per cycle), skipped for an
//   empty zone; the next query is taken in the cycle after the result is loaded
// accumulates and clears keep flowing while a query is in the divider
// reset: synchronous, active low; a clearing pass then zeroes all ZONES entries (1024 by default) of
//   the accumulator memory, s_ready stays low meanwhile, material_mask writes are still taken
`timescale 1ns / 1ps
`default_nettype none

module zone_volume_fraction_accumulator #(
    parameter int ZONES     = zvfa_pkg::ZONES_DEF,
    parameter int MATERIALS = zvfa_pkg::MATERIALS_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,

    // material mask register
    input  wire logic                                cfg_we,
    input  wire logic [zvfa_pkg::MASK_W-1:0]         cfg_wdata,

    // command channel
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [1:0]                          s_opcode,
    input  wire logic [zvfa_pkg::ZONE_IDX_W-1:0]     s_zone_index,
    input  wire logic [zvfa_pkg::MAT_IDX_W-1:0]      s_material_index,
    input  wire logic [zvfa_pkg::VOL_W-1:0]          s_cell_volume,

    // result channel
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic [zvfa_pkg::FRAC_W-1:0]              m_volume_fraction,
    output logic                                     m_empty_zone
);

    localparam int RANGE_W = zvfa_pkg::ZONE_ADDR_MAX_W + 1;

    logic [MATERIALS-1:0]            mask_reg;
    logic [zvfa_pkg::MASK_W-1:0]     mask_vec;

    zvfa_pkg::op_t                   op_in;
    zvfa_pkg::store_req_t            req;
    zvfa_pkg::store_status_t         status;
    zvfa_pkg::query_rsp_t            rsp;
    zvfa_pkg::div_result_t           div_res;
    logic                            div_idle;
    logic                            out_load;

    logic                            m_valid_reg;
    logic [zvfa_pkg::FRAC_W-1:0]     m_frac_reg;
    logic                            m_empty_reg;

    // only the implemented materials keep a mask bit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg <= '0;
        end else if (cfg_we) begin
            mask_reg <= cfg_wdata[MATERIALS-1:0];
        end
    end

    always_comb begin
        mask_vec                = '0;
        mask_vec[MATERIALS-1:0] = mask_reg;
    end

    assign op_in = zvfa_pkg::op_t'(s_opcode);

    // a query waits while another one is on its way to the result register;
    // accumulate and clear only wait for the clearing pass
    assign s_ready = status.init_done &&
                     ((op_in != zvfa_pkg::OP_QUERY) || (!status.query_pending && div_idle));

    always_comb begin
        req.valid    = s_valid && s_ready;
        req.op       = op_in;
        req.in_range = RANGE_W'(s_zone_index) < RANGE_W'(ZONES);
        req.selected = mask_vec[s_material_index];
        req.zone     = zvfa_pkg::ZONE_ADDR_MAX_W'(s_zone_index);
        req.volume   = s_cell_volume;
    end

    // read-modify-write over the accumulator memory
    zvfa_store #(
        .ZONES (ZONES)
    ) u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (req),
        .status  (status),
        .rsp     (rsp)
    );

    // selected / total as Q1.16
    zvfa_divider u_divider (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rsp     (rsp),
        .take    (out_load),
        .result  (div_res),
        .idle    (div_idle)
    );

    // output register, refilled when empty or in the cycle the old result is transferred
    assign out_load = div_res.valid && (!m_valid_reg || m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_frac_reg  <= div_res.frac;
            m_empty_reg <= div_res.empty;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_volume_fraction = m_frac_reg;
    assign m_empty_zone      = m_empty_reg;

endmodule

`default_nettype wire

>>> hw/rtl/zvfa_store.sv
`timescale 1ns / 1ps
`default_nettype none

module zvfa_store #(
    parameter int ZONES = zvfa_pkg::ZONES_DEF
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire zvfa_pkg::store_req_t    req,
    output zvfa_pkg::store_status_t      status,
    output zvfa_pkg::query_rsp_t         rsp
);

    localparam int AW = $clog2(ZONES);

    zvfa_pkg::acc_pair_t mem [ZONES];

    logic                     init_done_reg;
    logic [AW-1:0]            clr_cnt_reg;

    zvfa_pkg::acc_pair_t      rd_data_reg;

    logic                     s1_valid_reg;
    zvfa_pkg::op_t            s1_op_reg;
    logic                     s1_in_range_reg;
    logic                     s1_sel_reg;
    logic [AW-1:0]            s1_addr_reg;
    logic [zvfa_pkg::VOL_W-1:0] s1_vol_reg;

    logic                     fwd_valid_reg;
    logic [AW-1:0]            fwd_addr_reg;
    zvfa_pkg::acc_pair_t      fwd_data_reg;

    zvfa_pkg::acc_pair_t      cur;
    zvfa_pkg::acc_pair_t      wr_data;
    logic                     wr_en;

    // clearing pass after reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            init_done_reg <= 1'b0;
            clr_cnt_reg   <= '0;
        end else if (!init_done_reg) begin
            if (clr_cnt_reg == AW'(ZONES - 1)) begin
                init_done_reg <= 1'b1;
            end
            clr_cnt_reg <= clr_cnt_reg + AW'(1);
        end
    end

    // memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (!init_done_reg) begin
            mem[clr_cnt_reg] <= '0;
        end else if (wr_en) begin
            mem[s1_addr_reg] <= wr_data;
        end
        rd_data_reg <= mem[req.zone[AW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg  <= req.valid;
            fwd_valid_reg <= wr_en;
        end
    end

    always_ff @(posedge aclk) begin
        s1_op_reg       <= req.op;
        s1_in_range_reg <= req.in_range;
        s1_sel_reg      <= req.selected;
        s1_addr_reg     <= req.zone[AW-1:0];
        s1_vol_reg      <= req.volume;
        fwd_addr_reg    <= s1_addr_reg;
        fwd_data_reg    <= wr_data;
    end

    // write of the previous cycle is not yet visible in the read data
    assign cur = (fwd_valid_reg && fwd_addr_reg == s1_addr_reg) ? fwd_data_reg : rd_data_reg;

    always_comb begin
        wr_en   = 1'b0;
        wr_data = cur;
        unique case (s1_op_reg)
            zvfa_pkg::OP_ACCUMULATE: begin
                wr_en         = s1_valid_reg && s1_in_range_reg;
                wr_data.total = zvfa_pkg::sat_add(cur.total, s1_vol_reg);
                if (s1_sel_reg) begin
                    wr_data.selected = zvfa_pkg::sat_add(cur.selected, s1_vol_reg);
                end
            end
            zvfa_pkg::OP_CLEAR: begin
                wr_en   = s1_valid_reg && s1_in_range_reg;
                wr_data = '0;
            end
            default: begin
            end
        endcase
    end

    assign rsp.valid = s1_valid_reg && (s1_op_reg == zvfa_pkg::OP_QUERY);
    assign rsp.empty = !s1_in_range_reg || (cur.total == '0);
    assign rsp.acc   = cur;

    assign status.init_done     = init_done_reg;
    assign status.query_pending = rsp.valid;

    a_no_transfer_while_clearing: assert property (@(posedge aclk) disable iff (!aresetn)
        !init_done_reg |-> !req.valid)
        else $error("transfer during clearing pass");

    a_forward_back_to_back: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(wr_en) && s1_valid_reg && s1_addr_reg == $past(s1_addr_reg)) |->
            (cur == $past(wr_data)))
        else $error("back-to-back access missed the previous write");

    a_selected_within_total: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> (wr_data.selected <= wr_data.total))
        else $error("selected volume above total");

endmodule

`default_nettype wire

>>> hw/rtl/zvfa_divider.sv
`timescale 1ns / 1ps
`default_nettype none

module zvfa_divider (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire zvfa_pkg::query_rsp_t rsp,
    input  wire logic                take,
    output zvfa_pkg::div_result_t    result,
    output logic                     idle
);

    localparam int STEP_W = $clog2(zvfa_pkg::QUO_STEPS);
    localparam int ACC_W  = zvfa_pkg::ACC_W;
    localparam int FRAC_W = zvfa_pkg::FRAC_W;

    zvfa_pkg::div_state_t state_reg, state_next;

    logic [ACC_W-1:0]  den_reg,   den_next;
    logic [ACC_W:0]    rem_reg,   rem_next;
    logic [FRAC_W-1:0] quo_reg,   quo_next;
    logic [STEP_W-1:0] step_reg,  step_next;
    logic              empty_reg, empty_next;

    logic [ACC_W:0]    shifted;
    logic              ge;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= zvfa_pkg::DIV_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        den_reg   <= den_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        step_reg  <= step_next;
        empty_reg <= empty_next;
    end

    // restoring division, first step compares the unshifted remainder
    assign shifted = (step_reg == '0) ? rem_reg : {rem_reg[ACC_W-1:0], 1'b0};
    assign ge      = shifted >= {1'b0, den_reg};

    always_comb begin
        state_next = state_reg;
        den_next   = den_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        step_next  = step_reg;
        empty_next = empty_reg;
        unique case (state_reg)
            zvfa_pkg::DIV_IDLE: begin
                if (rsp.valid) begin
                    den_next   = rsp.acc.total;
                    rem_next   = {1'b0, rsp.acc.selected};
                    quo_next   = '0;
                    step_next  = '0;
                    empty_next = rsp.empty;
                    state_next = rsp.empty ? zvfa_pkg::DIV_DONE : zvfa_pkg::DIV_RUN;
                end
            end
            zvfa_pkg::DIV_RUN: begin
                rem_next  = ge ? (shifted - {1'b0, den_reg}) : shifted;
                quo_next  = {quo_reg[FRAC_W-2:0], ge};
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(zvfa_pkg::QUO_STEPS - 1)) begin
                    state_next = zvfa_pkg::DIV_DONE;
                end
            end
            zvfa_pkg::DIV_DONE: begin
                if (take) begin
                    state_next = zvfa_pkg::DIV_IDLE;
                end
            end
            default: begin
                state_next = zvfa_pkg::DIV_IDLE;
            end
        endcase
    end

    assign result.valid = (state_reg == zvfa_pkg::DIV_DONE);
    assign result.empty = empty_reg;
    assign result.frac  = empty_reg ? '0 : quo_reg;
    assign idle         = (state_reg == zvfa_pkg::DIV_IDLE);

    a_start_only_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        rsp.valid |-> (state_reg == zvfa_pkg::DIV_IDLE))
        else $error("query reached a busy divider");

    a_fraction_at_most_one: assert property (@(posedge aclk) disable iff (!aresetn)
        result.valid |-> (result.frac <= zvfa_pkg::FRAC_ONE))
        else $error("fraction above one");

endmodule

`default_nettype wire

>>> bench/zone_volume_fraction_accumulator_test.sv
`timescale 1ns / 1ps

module zone_volume_fraction_accumulator_test;
    import zvfa_pkg::*;

    localparam int HALF_PERIOD   = 5;
    localparam int RESET_CYCLES  = 8;
    localparam int ZONE_COUNT    = ZONES_DEF;
    // slack on top of the time a query result takes after its transfer
    localparam int SETTLE_CYCLES = 30;
    // clearing pass plus ~900 transfers at worst gaps, stalls and divider time, several times over
    localparam int CYCLE_LIMIT   = 400_000;
    localparam int MAX_GAP       = 40;
    localparam int LONG_HOLD     = 600;
    // full-scale adds into one zone, large sums well below the ceiling
    localparam int FULL_ADDS     = 40;

    localparam logic [1:0]            OP_UNUSED = 2'd3;
    localparam logic [VOL_W-1:0]      VOL_MAX   = '1;
    localparam logic [ZONE_IDX_W-1:0] ZONE_LAST = ZONE_IDX_W'(ZONE_COUNT - 1);
    localparam logic [MAT_IDX_W-1:0]  MAT_LAST  = '1;

    typedef struct packed {
        logic [FRAC_W-1:0] fraction;
        logic              empty;
    } fraction_t;

    // dut ports, inputs all known from time zero
    logic                  aclk             = 1'b0;
    logic                  aresetn          = 1'b0;
    logic                  cfg_we           = 1'b0;
    logic [MASK_W-1:0]     cfg_wdata        = '0;
    logic                  s_valid          = 1'b0;
    logic                  s_ready;
    logic [1:0]            s_opcode         = '0;
    logic [ZONE_IDX_W-1:0] s_zone_index     = '0;
    logic [MAT_IDX_W-1:0]  s_material_index = '0;
    logic [VOL_W-1:0]      s_cell_volume    = '0;
    logic                  m_valid;
    logic                  m_ready          = 1'b0;
    logic [FRAC_W-1:0]     m_volume_fraction;
    logic                  m_empty_zone;

    // shadow of the block state, updated as each command transfer is taken
    bit   [MASK_W-1:0] selected_materials;
    bit   [ACC_W-1:0]  zone_total    [ZONE_COUNT];
    bit   [ACC_W-1:0]  zone_selected [ZONE_COUNT];
    fraction_t         expected_fractions[$];

    int   error_count    = 0;
    int   cycle_count    = 0;
    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    logic receiver_hold  = 1'b0;

    zone_volume_fraction_accumulator i_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_we            (cfg_we),
        .cfg_wdata         (cfg_wdata),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_opcode          (s_opcode),
        .s_zone_index      (s_zone_index),
        .s_material_index  (s_material_index),
        .s_cell_volume     (s_cell_volume),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_volume_fraction (m_volume_fraction),
        .m_empty_zone      (m_empty_zone)
    );

    always #HALF_PERIOD aclk = ~aclk;

    // watchdog, a hung handshake ends the run here
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // receiver: random stalls, or held off completely while receiver_hold is up
    always @(posedge aclk) begin
        m_ready <= !receiver_hold && ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic report_mismatch(input string what, input longint exp_val,
                                   input longint got_val);
        $display("mismatch at cycle %0d: %s expected %0d got %0d",
                 cycle_count, what, exp_val, got_val);
        error_count++;
    endtask

    // every result transfer is matched against the oldest pending query
    always @(posedge aclk) begin : check_results
        fraction_t oldest;
        if (aresetn && m_valid && m_ready) begin
            if (expected_fractions.size() == 0) begin
                report_mismatch("result with no query pending, fraction", -1,
                                m_volume_fraction);
            end else begin
                oldest = expected_fractions.pop_front();
                if (m_volume_fraction !== oldest.fraction)
                    report_mismatch("volume_fraction", oldest.fraction, m_volume_fraction);
                if (m_empty_zone !== oldest.empty)
                    report_mismatch("empty_zone", oldest.empty, m_empty_zone);
            end
        end
    end

    // accumulators stick at all ones instead of wrapping
    function automatic logic [ACC_W-1:0] add_clamped(input logic [ACC_W-1:0] acc,
                                                     input logic [VOL_W-1:0] vol);
        logic [ACC_W:0] sum;
        sum = {1'b0, acc} + (ACC_W + 1)'(vol);
        return sum[ACC_W] ? {ACC_W{1'b1}} : sum[ACC_W-1:0];
    endfunction

    // selected/total as q1.16, truncated, an empty zone reads as zero with the flag
    function automatic fraction_t zone_fraction(input logic [ACC_W-1:0] sel,
                                                input logic [ACC_W-1:0] tot);
        logic [63:0] quotient;
        fraction_t   answer;
        answer = '0;
        if (tot == '0) begin
            answer.empty = 1'b1;
        end else begin
            quotient = {8'b0, sel, 16'b0} / 64'(tot);
            if (quotient > 64'(FRAC_ONE))
                quotient = 64'(FRAC_ONE);
            answer.fraction = quotient[FRAC_W-1:0];
        end
        return answer;
    endfunction

    // advance the shadow state by one accepted command
    task automatic apply_command(input logic [1:0] op, input logic [ZONE_IDX_W-1:0] zone,
                                 input logic [MAT_IDX_W-1:0] mat,
                                 input logic [VOL_W-1:0] vol);
        case (op)
            OP_ACCUMULATE: begin
                zone_total[zone] = add_clamped(zone_total[zone], vol);
                if (selected_materials[mat])
                    zone_selected[zone] = add_clamped(zone_selected[zone], vol);
            end
            OP_QUERY: begin
                expected_fractions = {expected_fractions,
                                      zone_fraction(zone_selected[zone], zone_total[zone])};
            end
            OP_CLEAR: begin
                zone_total[zone]    = '0;
                zone_selected[zone] = '0;
            end
            default: begin
                // unused opcode leaves everything alone
            end
        endcase
    endtask

    // one command transfer; valid stays up into the next call when there is no gap,
    // so a caller that consumes time in between lowers it first
    task automatic send_command(input logic [1:0] op, input logic [ZONE_IDX_W-1:0] zone,
                                input logic [MAT_IDX_W-1:0] mat,
                                input logic [VOL_W-1:0] vol);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap != 0) begin
            // junk payload while idle
            s_valid          <= 1'b0;
            s_opcode         <= 2'($urandom);
            s_zone_index     <= ZONE_IDX_W'($urandom);
            s_material_index <= MAT_IDX_W'($urandom);
            s_cell_volume    <= VOL_W'($urandom);
            repeat (gap) @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_opcode         <= op;
        s_zone_index     <= zone;
        s_material_index <= mat;
        s_cell_volume    <= vol;
        do @(posedge aclk); while (!s_ready);
        apply_command(op, zone, mat, vol);
    endtask

    // sender pauses until every query has answered, then lets the pipeline empty
    task automatic wait_for_results();
        s_valid <= 1'b0;
        while (expected_fractions.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // mask register, written only while the block is idle: the caller keeps to it, the task does not check
    task automatic write_mask(input logic [MASK_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        selected_materials = value;
    endtask

    task automatic hold_receiver(input int cycles);
        receiver_hold <= 1'b1;
        repeat (cycles) @(posedge aclk);
        receiver_hold <= 1'b0;
    endtask

    // edges of every field, every opcode, empty zones, truncation, clears
    task automatic test_directed();
        // only the first and last material count
        write_mask({1'b1, 62'b0, 1'b1});
        send_command(OP_QUERY,      '0,        '0,       '0);      // never touched, empty
        send_command(OP_ACCUMULATE, '0,        '0,       VOL_MAX); // selected
        send_command(OP_ACCUMULATE, '0,        6'd1,     VOL_MAX); // not selected
        send_command(OP_QUERY,      '0,        '0,       '0);      // exactly one half
        send_command(OP_ACCUMULATE, ZONE_LAST, MAT_LAST, 24'd1);
        send_command(OP_QUERY,      ZONE_LAST, '0,       '0);      // exactly one
        send_command(OP_ACCUMULATE, ZONE_LAST, 6'd62,    '0);      // zero volume adds nothing
        send_command(OP_QUERY,      ZONE_LAST, '0,       '0);
        send_command(OP_ACCUMULATE, 10'd5,     6'd2,     24'd3);
        send_command(OP_QUERY,      10'd5,     '0,       '0);      // nothing selected
        send_command(OP_ACCUMULATE, 10'd5,     '0,       24'd1);
        send_command(OP_QUERY,      10'd5,     '0,       '0);      // one quarter
        send_command(OP_ACCUMULATE, 10'd7,     '0,       '0);
        send_command(OP_QUERY,      10'd7,     '0,       '0);      // total still zero
        send_command(OP_ACCUMULATE, 10'd9,     '0,       24'd1);
        send_command(OP_ACCUMULATE, 10'd9,     6'd33,    24'd2);
        send_command(OP_QUERY,      10'd9,     '0,       '0);      // one third, truncated
        send_command(OP_CLEAR,      '0,        '0,       '0);
        send_command(OP_QUERY,      '0,        '0,       '0);      // cleared reads empty
        send_command(OP_UNUSED,     ZONE_LAST, MAT_LAST, VOL_MAX); // ignored
        send_command(OP_QUERY,      ZONE_LAST, '0,       '0);
        send_command(OP_CLEAR,      ZONE_LAST, '0,       '0);
        send_command(OP_CLEAR,      ZONE_LAST, '0,       '0);      // clear of an empty zone
        send_command(OP_QUERY,      ZONE_LAST, '0,       '0);
    endtask

    // random commands, mostly aimed at a few hot zones so sums grow and get queried
    task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                       input logic [MASK_W-1:0] mask, input int count);
        logic [ZONE_IDX_W-1:0] hot_zones [6];
        logic [ZONE_IDX_W-1:0] zone;
        logic [VOL_W-1:0]      vol;
        logic [1:0]            op;
        int                    pick;
        wait_for_results();
        write_mask(mask);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        foreach (hot_zones[i])
            hot_zones[i] = ZONE_IDX_W'($urandom);
        repeat (count) begin
            pick = $urandom_range(99);
            if (pick < 55)
                op = OP_ACCUMULATE;
            else if (pick < 85)
                op = OP_QUERY;
            else if (pick < 93)
                op = OP_CLEAR;
            else
                op = OP_UNUSED;
            if ($urandom_range(99) < 80)
                zone = hot_zones[$urandom_range(5)];
            else
                zone = ZONE_IDX_W'($urandom);
            pick = $urandom_range(99);
            if (pick < 10)
                vol = VOL_MAX;
            else if (pick < 20)
                vol = VOL_W'($urandom_range(15));
            else if (pick < 25)
                vol = '0;
            else
                vol = VOL_W'($urandom);
            send_command(op, zone, MAT_IDX_W'($urandom), vol);
        end
    endtask

    // receiver goes dark while queries keep coming, so the block has to stall its input
    task automatic test_backpressure();
        logic [ZONE_IDX_W-1:0] zone;
        wait_for_results();
        write_mask({$urandom, $urandom});
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        fork
            hold_receiver(LONG_HOLD);
        join_none
        repeat (60) begin
            zone = ZONE_IDX_W'($urandom_range(7));
            send_command(OP_ACCUMULATE, zone, MAT_IDX_W'($urandom), VOL_W'($urandom));
            send_command(OP_QUERY, zone, MAT_IDX_W'($urandom), VOL_W'($urandom));
        end
        // full pause until the backlog has drained, then a short burst to see it resume
        wait_for_results();
        repeat (10)
            send_command(OP_QUERY, ZONE_IDX_W'($urandom_range(7)), '0, '0);
    endtask

    // full-scale volumes piling up in one zone, queried as the sums grow
    task automatic test_full_scale();
        logic [ZONE_IDX_W-1:0] zone;
        wait_for_results();
        // everything but material 0 counts
        write_mask(~{{(MASK_W - 1){1'b0}}, 1'b1});
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        zone = ZONE_IDX_W'($urandom);
        send_command(OP_CLEAR, zone, '0, '0);
        for (int i = 0; i < FULL_ADDS; i++) begin
            send_command(OP_ACCUMULATE, zone,
                         (i % 3 == 0) ? MAT_IDX_W'($urandom_range(1, 63)) : '0, VOL_MAX);
            if (i % 8 == 7)
                send_command(OP_QUERY, zone, '0, '0);
        end
        send_command(OP_QUERY, zone, '0, '0);
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // mask write lands during the clearing pass, the first transfer waits for s_ready
        test_directed();
        test_random_traffic(0,  0,  '1,                    180);
        test_random_traffic(71, 0,  '0,                    180);
        test_random_traffic(0,  71, {$urandom, $urandom},  180);
        test_random_traffic(23, 23, 64'h5555_AAAA_0F0F_F0F0, 180);
        test_backpressure();
        test_full_scale();
        wait_for_results();

        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/zvfa_pkg.sv
hw/rtl/zvfa_store.sv
hw/rtl/zvfa_divider.sv
hw/rtl/zone_volume_fraction_accumulator.sv
bench/zone_volume_fraction_accumulator_test.sv
